// ----- rtl/core/bfa_pkg.sv -----
// Shared codes and types for the bitmap frame allocator.
// No dependencies; compiled first.
`default_nettype none

package bfa_pkg;

  // Item mode codes
  localparam logic [1:0] MODE_INIT    = 2'd0;
  localparam logic [1:0] MODE_ALLOC   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_REGION_BASE       = 3'd0;
  localparam logic [2:0] CFG_FRAME_COUNT       = 3'd1;
  localparam logic [2:0] CFG_RESERVE_ONE_FIRST = 3'd2;
  localparam logic [2:0] CFG_RESERVE_ONE_END   = 3'd3;
  localparam logic [2:0] CFG_RESERVE_TWO_FIRST = 3'd4;
  localparam logic [2:0] CFG_RESERVE_TWO_END   = 3'd5;

  localparam int          CFG_INDEX_W  = 3;
  localparam int          CFG_DATA_W   = 32;
  localparam logic [31:0] REGION_RESET = 32'h0010_0000;
  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_ALLOC_SUM,
    ST_ALLOC_WORD,
    ST_REL_MOD,
    ST_EMIT
  } bfa_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/bfa_ifs.sv -----
// Request and response channel interfaces of the frame allocator.
// Valid/ready handshake; no package dependency.
`default_nettype none

interface bfa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] release_address;

  modport source (output valid, output mode, output release_address, input ready);
  modport sink (input valid, input mode, input release_address, output ready);
endinterface

interface bfa_rsp_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic [31:0] frame_address;

  modport source (output valid, output success, output frame_address, input ready);
  modport sink (input valid, input success, input frame_address, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bfa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// Standalone; used for the usage bitmap and its summary.
`default_nettype none

module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bitmap_frame_allocator_unit.sv -----
// Top level of the first-fit bitmap page frame allocator.
// Depends on bfa_pkg, bfa_ifs (bfa_req_if, bfa_rsp_if) and bfa_ram.
//
//  channel  direction  handshake       payload
//  req      in         valid/ready     mode[1:0], release_address[31:0]
//  rsp      out        valid/ready     success, frame_address[31:0]
//  cfg      in         cfg_we only     cfg_index[2:0], cfg_data[31:0]
//
// After reset a clearing pass fills the bitmap with ones and the summary with
// zeros; req.ready stays low meanwhile. Alloc reads the summary, then the
// first free bitmap word, then writes both (no read when no group has a free
// word, no word read when the first free word lies past the frame count).
// Release reads both words, then writes both (no access when out of range); an
// unused mode skips to the result; init writes one bitmap word per cycle.
// The response register decouples the sides: a new item is taken while a
// result waits; a finished item stalls in its last state until rsp drains.
`default_nettype none

module bitmap_frame_allocator_unit #(
  parameter int MAX_FRAMES = 32768,
  parameter int PAGE_SHIFT = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bfa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bfa_pkg::CFG_DATA_W-1:0]  cfg_data,
  bfa_req_if.sink                            req,
  bfa_rsp_if.source                          rsp
);

  import bfa_pkg::*;

  localparam int WORD_COUNT  = (MAX_FRAMES + 31) / 32;
  localparam int GROUP_COUNT = (WORD_COUNT + 31) / 32;
  localparam int WADDR_W     = WORD_COUNT > 1 ? $clog2(WORD_COUNT) : 1;
  localparam int GADDR_W     = GROUP_COUNT > 1 ? $clog2(GROUP_COUNT) : 1;
  localparam int CNT_W       = $clog2(MAX_FRAMES + 1);

  // Configuration registers
  logic [31:0] region_base;
  logic [15:0] frame_count;
  logic [15:0] reserve_one_first;
  logic [15:0] reserve_one_end;
  logic [15:0] reserve_two_first;
  logic [15:0] reserve_two_end;

  // Control and working registers
  bfa_state_t               state, state_next;
  logic [WADDR_W-1:0]       walk, walk_next;
  logic [GADDR_W-1:0]       grp_sel, grp_sel_next;
  logic [4:0]               word_low, word_low_next;
  logic [4:0]               bit_sel, bit_sel_next;
  logic [31:0]              sum_hold, sum_hold_next;
  logic [31:0]              acc, acc_next;
  logic                     res_ok, res_ok_next;
  logic [31:0]              res_addr, res_addr_next;
  logic [GROUP_COUNT-1:0]   top, top_next;
  logic                     out_valid, out_valid_next;
  logic                     out_success;
  logic [31:0]              out_addr;
  logic                     out_load;

  // RAM ports
  logic               word_we, word_re;
  logic [WADDR_W-1:0] word_waddr, word_raddr;
  logic [31:0]        word_wdata, word_rdata;
  logic               sum_we, sum_re;
  logic [GADDR_W-1:0] sum_waddr, sum_raddr;
  logic [31:0]        sum_wdata, sum_rdata;

  // Derived values
  logic [CNT_W-1:0]   count_c;
  logic [31:0]        count32;
  logic [31:0]        words_lim;
  logic [31:0]        walk32;
  logic               walk_last;
  logic [31:0]        free_mask;
  logic [31:0]        init_word;
  logic [31:0]        acc_cur;
  logic [GADDR_W-1:0] top_first;
  logic [4:0]         sum_low;
  logic [31:0]        alloc_widx;
  logic [4:0]         free_bit;
  logic [31:0]        alloc_word;
  logic [31:0]        alloc_sum;
  logic [31:0]        alloc_frame;
  logic [31:0]        rel_diff;
  logic [31:0]        rel_idx;
  logic               rel_ok;
  logic               req_fire;

  // Lowest set bit of a 32-bit word
  function automatic logic [4:0] lowest_set(input logic [31:0] v);
    logic [4:0] pos;
    pos = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        pos = 5'(i);
      end
    end
    return pos;
  endfunction

  // Bits of word w whose frame index lies below lim
  function automatic logic [31:0] below_mask(input logic [31:0] lim, input logic [31:0] w);
    logic [31:0] lim_word;
    lim_word = lim >> 5;
    if (lim_word > w) begin
      below_mask = ALL_ONES;
    end else if (lim_word == w) begin
      below_mask = (32'd1 << lim[4:0]) - 32'd1;
    end else begin
      below_mask = 32'd0;
    end
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base       <= REGION_RESET;
      frame_count       <= 16'd0;
      reserve_one_first <= 16'd0;
      reserve_one_end   <= 16'd0;
      reserve_two_first <= 16'd0;
      reserve_two_end   <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REGION_BASE:       region_base       <= cfg_data;
        CFG_FRAME_COUNT:       frame_count       <= cfg_data[15:0];
        CFG_RESERVE_ONE_FIRST: reserve_one_first <= cfg_data[15:0];
        CFG_RESERVE_ONE_END:   reserve_one_end   <= cfg_data[15:0];
        CFG_RESERVE_TWO_FIRST: reserve_two_first <= cfg_data[15:0];
        CFG_RESERVE_TWO_END:   reserve_two_end   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Clamp frame count and derive the searched word limit
  assign count_c   = (32'(frame_count) > 32'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                          : CNT_W'(frame_count);
  assign count32   = 32'(count_c);
  assign words_lim = (count32 + 32'd31) >> 5;

  // Init word: free below count, minus both reserved ranges
  assign walk32    = 32'(walk);
  assign walk_last = (walk == WADDR_W'(WORD_COUNT - 1));
  assign free_mask = below_mask(count32, walk32)
                   & ~(below_mask(32'(reserve_one_end), walk32)
                       & ~below_mask(32'(reserve_one_first), walk32))
                   & ~(below_mask(32'(reserve_two_end), walk32)
                       & ~below_mask(32'(reserve_two_first), walk32));
  assign init_word = ~free_mask;
  assign acc_cur   = acc | ((|free_mask) ? (32'd1 << walk32[4:0]) : 32'd0);

  // First group with a free word
  always_comb begin
    top_first = '0;
    for (int i = GROUP_COUNT - 1; i >= 0; i--) begin
      if (top[i]) begin
        top_first = GADDR_W'(i);
      end
    end
  end

  // Alloc search and update
  assign sum_low     = lowest_set(sum_rdata);
  assign alloc_widx  = 32'({grp_sel, sum_low});
  assign free_bit    = lowest_set(~word_rdata);
  assign alloc_word  = word_rdata | (32'd1 << free_bit);
  assign alloc_sum   = (alloc_word == ALL_ONES) ? (sum_hold & ~(32'd1 << word_low)) : sum_hold;
  assign alloc_frame = 32'({grp_sel, word_low, free_bit});

  // Release range check
  assign rel_diff = req.release_address - region_base;
  assign rel_idx  = rel_diff >> PAGE_SHIFT;
  assign rel_ok   = (req.release_address >= region_base) && (rel_idx < count32);

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_load  = (state == ST_EMIT) && (!out_valid || rsp.ready);

  // Sequencer: next state, RAM accesses and working values
  always_comb begin
    state_next    = state;
    walk_next     = walk;
    grp_sel_next  = grp_sel;
    word_low_next = word_low;
    bit_sel_next  = bit_sel;
    sum_hold_next = sum_hold;
    acc_next      = acc;
    res_ok_next   = res_ok;
    res_addr_next = res_addr;
    top_next      = top;
    word_we       = 1'b0;
    word_waddr    = walk;
    word_wdata    = ALL_ONES;
    word_re       = 1'b0;
    word_raddr    = walk;
    sum_we        = 1'b0;
    sum_waddr     = grp_sel;
    sum_wdata     = 32'd0;
    sum_re        = 1'b0;
    sum_raddr     = grp_sel;

    unique case (state)
      // Fill the bitmap with ones and the summary with zeros
      ST_CLEAR: begin
        word_we    = 1'b1;
        word_waddr = walk;
        word_wdata = ALL_ONES;
        sum_we     = (walk32 < 32'(GROUP_COUNT));
        sum_waddr  = GADDR_W'(walk32);
        sum_wdata  = 32'd0;
        walk_next  = walk + WADDR_W'(1);
        if (walk_last) begin
          walk_next  = '0;
          state_next = ST_IDLE;
        end
      end

      // Take an item and start its first access
      ST_IDLE: begin
        if (req_fire) begin
          res_ok_next   = 1'b0;
          res_addr_next = 32'd0;
          unique case (req.mode)
            MODE_INIT: begin
              walk_next  = '0;
              acc_next   = 32'd0;
              state_next = ST_INIT;
            end
            MODE_ALLOC: begin
              if (|top) begin
                sum_re       = 1'b1;
                sum_raddr    = top_first;
                grp_sel_next = top_first;
                state_next   = ST_ALLOC_SUM;
              end else begin
                state_next = ST_EMIT;
              end
            end
            MODE_RELEASE: begin
              if (rel_ok) begin
                word_re       = 1'b1;
                word_raddr    = WADDR_W'(rel_idx >> 5);
                sum_re        = 1'b1;
                sum_raddr     = GADDR_W'(rel_idx >> 10);
                grp_sel_next  = GADDR_W'(rel_idx >> 10);
                word_low_next = rel_idx[9:5];
                bit_sel_next  = rel_idx[4:0];
                state_next    = ST_REL_MOD;
              end else begin
                state_next = ST_EMIT;
              end
            end
            default: begin
              state_next = ST_EMIT;
            end
          endcase
        end
      end

      // Write one bitmap word, close the summary word at a group end
      ST_INIT: begin
        word_we    = 1'b1;
        word_waddr = walk;
        word_wdata = init_word;
        acc_next   = acc_cur;
        if ((walk32[4:0] == 5'd31) || walk_last) begin
          sum_we    = 1'b1;
          sum_waddr = GADDR_W'(walk32 >> 5);
          sum_wdata = acc_cur;
          top_next[GADDR_W'(walk32 >> 5)] = |acc_cur;
          acc_next  = 32'd0;
        end
        walk_next = walk + WADDR_W'(1);
        if (walk_last) begin
          walk_next   = '0;
          res_ok_next = 1'b1;
          state_next  = ST_EMIT;
        end
      end

      // Pick the first free word, drop if beyond the frame count
      ST_ALLOC_SUM: begin
        if (alloc_widx < words_lim) begin
          word_re       = 1'b1;
          word_raddr    = WADDR_W'(alloc_widx);
          sum_hold_next = sum_rdata;
          word_low_next = sum_low;
          state_next    = ST_ALLOC_WORD;
        end else begin
          state_next = ST_EMIT;
        end
      end

      // Mark the first free frame used, update summary
      ST_ALLOC_WORD: begin
        word_we       = 1'b1;
        word_waddr    = WADDR_W'({grp_sel, word_low});
        word_wdata    = alloc_word;
        sum_we        = 1'b1;
        sum_waddr     = grp_sel;
        sum_wdata     = alloc_sum;
        top_next[grp_sel] = |alloc_sum;
        res_ok_next   = 1'b1;
        res_addr_next = region_base + (alloc_frame << PAGE_SHIFT);
        state_next    = ST_EMIT;
      end

      // Clear the released bit, flag its word free
      ST_REL_MOD: begin
        word_we     = 1'b1;
        word_waddr  = WADDR_W'({grp_sel, word_low});
        word_wdata  = word_rdata & ~(32'd1 << bit_sel);
        sum_we      = 1'b1;
        sum_waddr   = grp_sel;
        sum_wdata   = sum_rdata | (32'd1 << word_low);
        top_next[grp_sel] = 1'b1;
        res_ok_next = 1'b1;
        state_next  = ST_EMIT;
      end

      // Hand the result to the response register
      ST_EMIT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Response register
  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_success <= res_ok;
      out_addr    <= res_addr;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      walk      <= '0;
      top       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      walk      <= walk_next;
      top       <= top_next;
      out_valid <= out_valid_next;
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    grp_sel  <= grp_sel_next;
    word_low <= word_low_next;
    bit_sel  <= bit_sel_next;
    sum_hold <= sum_hold_next;
    acc      <= acc_next;
    res_ok   <= res_ok_next;
    res_addr <= res_addr_next;
  end

  assign rsp.valid         = out_valid;
  assign rsp.success       = out_success;
  assign rsp.frame_address = out_addr;

  // Usage bitmap, one bit per frame
  bfa_ram #(
    .WIDTH (32),
    .DEPTH (WORD_COUNT)
  ) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (word_wdata),
    .re    (word_re),
    .raddr (word_raddr),
    .rdata (word_rdata)
  );

  // Summary, one bit per bitmap word that holds a free frame
  bfa_ram #(
    .WIDTH (32),
    .DEPTH (GROUP_COUNT)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .re    (sum_re),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/core/bfa_checker.sv -----
// Port-level checks for the frame allocator, bound to the top level.
// Depends on bitmap_frame_allocator_unit and its req/rsp interfaces.
`default_nettype none

module bfa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        rsp_success,
  input wire logic [31:0] rsp_frame_address
);

  // Clearing pass blocks items right after reset
  assert property (@(posedge clk) rst |=> !req_ready)
    else $error("item taken during clearing pass");

  // An accepted item keeps the block busy for the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second item taken back to back");

  // A failed result carries a zero address
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_success) |-> (rsp_frame_address == 32'd0))
    else $error("failed result with nonzero address");

  // A stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("result dropped while stalled");

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_success       (rsp.success),
  .rsp_frame_address (rsp.frame_address)
);

`default_nettype wire

// ----- tb/frame_outcome_checker.sv -----
// Response checker for the bitmap frame allocator: mirrors register writes,
// keeps its own usage bitmap and compares every response in order.
// Depends on bfa_pkg and the bfa_req_if / bfa_rsp_if interfaces.
`default_nettype none

module frame_outcome_checker #(
  parameter int MAX_FRAMES = 32768,
  parameter int PAGE_SHIFT = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [bfa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bfa_pkg::CFG_DATA_W-1:0]  cfg_data,
  bfa_req_if                                   req,
  bfa_rsp_if                                   rsp,
  output int                                   outcomes_owed,
  output int                                   bad_outcomes
);
  import bfa_pkg::*;

  localparam int WORDS = (MAX_FRAMES + 31) / 32;

  typedef struct packed {
    logic        success;
    logic [31:0] frame_address;
  } frame_outcome_t;

  // Shadow bitmap (bit set = frame used) and shadow registers
  logic [31:0]    usage_map [WORDS];
  logic [31:0]    base_reg;
  logic [15:0]    count_reg;
  logic [15:0]    one_first, one_end, two_first, two_end;
  frame_outcome_t outcome_q [$];
  int             mismatch_total;

  function automatic int unsigned clamp_frames(input logic [15:0] v);
    return (int'(v) > MAX_FRAMES) ? MAX_FRAMES : int'(v);
  endfunction

  // Mark a reserved range used; an empty or inverted range marks nothing
  function automatic void mark_range_used(input logic [15:0] first, input logic [15:0] last);
    int unsigned lo, hi;
    lo = clamp_frames(first);
    hi = clamp_frames(last);
    for (int unsigned i = lo; i < hi; i++) usage_map[i / 32][i % 32] = 1'b1;
  endfunction

  // Apply one request to the shadow bitmap and return the response it earns
  function automatic frame_outcome_t serve_frame_request(input logic [1:0] mode,
                                                         input logic [31:0] addr);
    frame_outcome_t o;
    int unsigned    count, words, idx;
    logic [31:0]    offset;
    bit             found;
    o = '0;
    count = clamp_frames(count_reg);
    case (mode)
      MODE_INIT: begin
        for (int w = 0; w < WORDS; w++) usage_map[w] = ALL_ONES;
        for (int unsigned i = 0; i < count; i++) usage_map[i / 32][i % 32] = 1'b0;
        mark_range_used(one_first, one_end);
        mark_range_used(two_first, two_end);
        o.success = 1'b1;
      end
      MODE_ALLOC: begin
        // first fit over the words that hold usable frames
        words = (count + 31) / 32;
        found = 1'b0;
        for (int unsigned w = 0; w < words && !found; w++) begin
          for (int b = 0; b < 32 && !found; b++) begin
            if (!usage_map[w][b]) begin
              idx = w * 32 + b;
              usage_map[w][b] = 1'b1;
              o.success = 1'b1;
              o.frame_address = base_reg + (32'(idx) << PAGE_SHIFT);
              found = 1'b1;
            end
          end
        end
      end
      MODE_RELEASE: begin
        if (addr >= base_reg) begin
          offset = addr - base_reg;
          idx = offset >> PAGE_SHIFT;
          if (idx < count) begin
            usage_map[idx / 32][idx % 32] = 1'b0;
            o.success = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin : track
    frame_outcome_t got, want;
    if (rst) begin
      for (int w = 0; w < WORDS; w++) usage_map[w] = ALL_ONES;
      base_reg  = REGION_RESET;
      count_reg = '0;
      one_first = '0;
      one_end   = '0;
      two_first = '0;
      two_end   = '0;
      outcome_q.delete();
      mismatch_total = 0;
    end else begin
      // mirror register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_REGION_BASE:       base_reg  = cfg_data;
          CFG_FRAME_COUNT:       count_reg = cfg_data[15:0];
          CFG_RESERVE_ONE_FIRST: one_first = cfg_data[15:0];
          CFG_RESERVE_ONE_END:   one_end   = cfg_data[15:0];
          CFG_RESERVE_TWO_FIRST: two_first = cfg_data[15:0];
          CFG_RESERVE_TWO_END:   two_end   = cfg_data[15:0];
          default: ;
        endcase
      end
      // compare the item taken on rsp with the oldest prediction
      if (rsp.valid && rsp.ready) begin
        got.success       = rsp.success;
        got.frame_address = rsp.frame_address;
        if (outcome_q.size() == 0) begin
          if (mismatch_total < 10)
            $display("%0t: response with none pending: success %0b address %h",
                     $time, got.success, got.frame_address);
          mismatch_total++;
        end else begin
          want = outcome_q.pop_front();
          if (got.success !== want.success || got.frame_address !== want.frame_address) begin
            if (mismatch_total < 10)
              $display("%0t: mismatch: expected success %0b address %h, got success %0b address %h",
                       $time, want.success, want.frame_address, got.success, got.frame_address);
            mismatch_total++;
          end
        end
      end
      // predict the item taken on req
      if (req.valid && req.ready)
        outcome_q.push_back(serve_frame_request(req.mode, req.release_address));
    end
    outcomes_owed <= outcome_q.size();
    bad_outcomes  <= mismatch_total;
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Top of the frame allocator testbench: clock, reset, register writes and
// request/response traffic with idling and back-pressure; gives the verdict.
// Depends on bfa_pkg, bfa_ifs, bitmap_frame_allocator_unit and frame_outcome_checker.
`default_nettype none

module testbench;
  import bfa_pkg::*;

  localparam int         MAX_FRAMES      = 32768;
  localparam int         PAGE_SHIFT      = 12;
  localparam int         RANDOM_ITEMS    = 1400;
  localparam int         WATCHDOG_LIMIT  = 20000;
  // longer than an init walk, so the block still fills up behind one
  localparam int         RSP_HOLD_CYCLES = 1500;
  localparam logic [1:0] MODE_UNUSED     = 2'd3;

  logic                   clk, rst, cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   calm, squeeze;
  int                     outcomes_owed, bad_outcomes, quiet_cycles, items_sent;

  bfa_req_if req_ch();
  bfa_rsp_if rsp_ch();

  bitmap_frame_allocator_unit #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  frame_outcome_checker #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) outcome_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .outcomes_owed (outcomes_owed),
    .bad_outcomes  (bad_outcomes)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bitmap_frame_allocator_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drain responses; hold off for a long stretch once per squeeze request
  initial begin : rsp_side
    bit held;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !held) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
      end else if (!squeeze) begin
        held = 1'b0;
      end
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Write all six registers; 16-bit ones carry random upper bits
  task automatic set_frames(input logic [31:0] base, input logic [15:0] count,
                            input logic [15:0] r1f, input logic [15:0] r1e,
                            input logic [15:0] r2f, input logic [15:0] r2e);
    write_reg(CFG_REGION_BASE, base);
    write_reg(CFG_FRAME_COUNT, {16'($urandom()), count});
    write_reg(CFG_RESERVE_ONE_FIRST, {16'($urandom()), r1f});
    write_reg(CFG_RESERVE_ONE_END, {16'($urandom()), r1e});
    write_reg(CFG_RESERVE_TWO_FIRST, {16'($urandom()), r2f});
    write_reg(CFG_RESERVE_TWO_END, {16'($urandom()), r2e});
  endtask

  // Offer one item, idling at random first, and hold it until taken
  task automatic send_item(input logic [1:0] mode, input logic [31:0] addr);
    while (!calm && $urandom_range(0, 99) < 20) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.mode            <= mode;
    req_ch.release_address <= addr;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stop offering and wait until every response is back
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outcomes_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void pick_reserve(input int unsigned span,
                                       output logic [15:0] first, output logic [15:0] last);
    first = 16'($urandom_range(0, span));
    case ($urandom_range(0, 5))
      0:       last = first;
      1:       last = 16'($urandom_range(0, first));
      2:       last = 16'($urandom());
      default: last = first + 16'($urandom_range(1, 8));
    endcase
  endfunction

  // One random phase: fresh registers, usually an init, then mixed traffic
  task automatic random_phase(input int n, input bit pressure);
    int unsigned pick, count, usable, k;
    logic [31:0] base, addr;
    logic [15:0] r1f, r1e, r2f, r2e;
    pick = $urandom_range(0, 9);
    if (pick < 6) count = $urandom_range(1, 96);
    else if (pick < 8) count = $urandom_range(97, 3000);
    else if (pick == 8) count = $urandom_range(0, 1);
    else count = $urandom_range(MAX_FRAMES, 65535);
    usable = (count > MAX_FRAMES) ? MAX_FRAMES : count;
    case ($urandom_range(0, 3))
      0:       base = $urandom() & 32'hFFFF_F000;
      1:       base = $urandom();
      2:       base = 32'hFFFF_F000 - ($urandom_range(0, 64) << PAGE_SHIFT);
      default: base = $urandom_range(0, 3) << 20;
    endcase
    pick_reserve(usable + 8, r1f, r1e);
    pick_reserve(usable + 8, r2f, r2e);
    set_frames(base, 16'(count), r1f, r1e, r2f, r2e);
    // sometimes keep the old bitmap under the new registers
    if ($urandom_range(0, 4) != 0) send_item(MODE_INIT, $urandom());
    if (pressure) squeeze <= 1'b1;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_item(MODE_ALLOC, $urandom());
      end else if (pick < 80) begin
        // release a frame in range, mostly among the low ones that get granted
        k = (usable == 0) ? 0 :
            $urandom_range(0, (usable > 64 && $urandom_range(0, 3) != 0) ? 63 : usable - 1);
        addr = base + 32'(k << PAGE_SHIFT) + 32'($urandom_range(0, (1 << PAGE_SHIFT) - 1));
        send_item(MODE_RELEASE, addr);
      end else if (pick < 90) begin
        addr = $urandom_range(0, 1) ? $urandom() : base - $urandom_range(1, 1 << PAGE_SHIFT);
        send_item(MODE_RELEASE, addr);
      end else if (pick < 96) begin
        send_item(MODE_UNUSED, $urandom());
      end else begin
        send_item(MODE_INIT, $urandom());
      end
      items_sent++;
    end
    if (pressure) squeeze <= 1'b0;
    settle();
  endtask

  initial begin : stimulus
    int phase;
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    calm                   = 1'b0;
    squeeze                = 1'b0;
    req_ch.valid           = 1'b0;
    req_ch.mode            = MODE_INIT;
    req_ch.release_address = '0;
    items_sent             = 0;
    phase                  = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset registers, nothing usable yet
    send_item(MODE_ALLOC, '0);
    send_item(MODE_RELEASE, REGION_RESET);
    send_item(MODE_UNUSED, ALL_ONES);
    send_item(MODE_INIT, '0);
    send_item(MODE_ALLOC, ALL_ONES);
    settle();

    // base near the top so grants wrap; reserves at the bottom and across the end of the count
    set_frames(32'hFFFF_E000, 16'd40, 16'd0, 16'd2, 16'd38, 16'd45);
    send_item(MODE_INIT, '0);
    send_item(MODE_ALLOC, '0);
    send_item(MODE_ALLOC, '0);
    send_item(MODE_RELEASE, 32'h0000_0ABC);
    send_item(MODE_RELEASE, ALL_ONES);
    send_item(MODE_ALLOC, '0);
    settle();

    // oversized count, inverted and clamped-empty reserves
    set_frames(32'h0, 16'hFFFF, 16'd7, 16'd3, 16'hFFFF, 16'hFFFF);
    send_item(MODE_INIT, ALL_ONES);
    send_item(MODE_ALLOC, '0);
    send_item(MODE_RELEASE, ALL_ONES);
    send_item(MODE_RELEASE, 32'h07FF_FFFF);
    send_item(MODE_RELEASE, 32'h0000_0123);
    send_item(MODE_ALLOC, '0);
    settle();

    // full count with every frame reserved
    set_frames(REGION_RESET, 16'h8000, 16'd0, 16'hFFFF, 16'd0, 16'd0);
    send_item(MODE_INIT, '0);
    send_item(MODE_ALLOC, '0);
    send_item(MODE_UNUSED, REGION_RESET);
    send_item(MODE_RELEASE, REGION_RESET);
    send_item(MODE_ALLOC, '0);
    settle();

    while (items_sent < RANDOM_ITEMS) begin
      calm <= (phase >= 6 && phase < 10);
      random_phase($urandom_range(20, 60), phase == 3 || phase == 17);
      phase++;
    end
    settle();

    if (bad_outcomes == 0) begin
      $display("bitmap_frame_allocator_unit test passed");
    end else begin
      $display("bitmap_frame_allocator_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
